FILE: hdl/tmt_pkg.sv
// tmt_pkg: shared types and constants of the trapezoid motion timeline
// depends on nothing; imported by every other file of the block but tmt_if
`timescale 1ns / 1ps

package tmt_pkg;

   localparam int MAX_EVENTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   // register indexes of the configuration port
   localparam logic [1:0] REG_ACCEL   = 2'd0;
   localparam logic [1:0] REG_DECEL   = 2'd1;
   localparam logic [1:0] REG_SPACING = 2'd2;
   localparam logic [1:0] REG_BOUND   = 2'd3;

   // event kinds
   localparam logic [1:0] K_ACCEL  = 2'd0;
   localparam logic [1:0] K_CRUISE = 2'd1;
   localparam logic [1:0] K_BRAKE  = 2'd2;
   localparam logic [1:0] K_STOP   = 2'd3;

   // arithmetic unit operations
   typedef enum logic [1:0] {
      AM_MULDIV,
      AM_MUL,
      AM_SQRT
   } arith_mode_type;

   typedef enum logic [2:0] {
      AR_IDLE,
      AR_MUL,
      AR_CHK,
      AR_DIV,
      AR_SQRT
   } ar_state_type;

   // calculations run on the shared arithmetic unit
   typedef enum logic [4:0] {
      C_NONE,
      C_SA,
      C_SD,
      C_TA,
      C_TD,
      C_TC,
      C_AD,
      C_Q,
      C_VP,
      C_SPK,
      C_AQ,
      C_ASQ,
      C_CR,
      C_B0,
      C_VV,
      C_P,
      C_BSQ,
      C_BR
   } calc_type;

   // register operations of the datapath
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DS,
      OP_OFFMAX,
      OP_MDINC
   } dp_op_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_GO,
      CS_WAIT,
      CS_FIT,
      CS_PHASE,
      CS_CHECK,
      CS_MS,
      CS_STOP
   } ctl_state_type;

   typedef struct packed {
      dp_op_type  op;
      calc_type   calc;
      logic       start;
      logic       emit;
      logic [1:0] kind;
      logic       is_ms;
      logic       last;
      logic       drop;
      logic [1:0] phase;
      logic       trap;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic fits;
      logic ms_more;
      logic a_small;
      logic d_small;
   } status_type;

endpackage

FILE: hdl/tmt_if.sv
// tmt_if: request and result channel interfaces of the motion timeline
// no dependencies
`timescale 1ns / 1ps

interface tmt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] track_length;
   logic [31:0] speed_cap;

   modport source (output valid, track_length, speed_cap, input ready);
   modport sink (input valid, track_length, speed_cap, output ready);
endinterface

interface tmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic        is_milestone;
   logic [31:0] event_time;
   logic [31:0] event_distance;
   logic        last_event;
   logic        dropped_milestones;

   modport source (output valid, event_kind, is_milestone, event_time, event_distance,
                   last_event, dropped_milestones, input ready);
   modport sink (input valid, event_kind, is_milestone, event_time, event_distance,
                 last_event, dropped_milestones, output ready);
endinterface

FILE: hdl/trapezoid_motion_timeline.sv
// Rest-to-rest move planner: one request is taken at a time and answered by its
// timeline of phase, milestone and stop events. All arithmetic runs on one shared
// unit that produces one quotient bit or one root digit per cycle; it performs a
// multiply-divide, a plain multiply or a square root. A new request is taken only
// after the stop event has been placed in the output register.
// depends on tmt_pkg, tmt_if, tmt_ctrl, tmt_datapath
`timescale 1ns / 1ps

module trapezoid_motion_timeline import tmt_pkg::*; #(
   parameter int MAX_EVENTS = MAX_EVENTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tmt_req_if.sink     req_chan,
   tmt_rsp_if.source   rsp_chan,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   tmt_ctrl #(.MAX_EVENTS(MAX_EVENTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tmt_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .track_length       (req_chan.track_length),
      .speed_cap          (req_chan.speed_cap),
      .cmd                (cmd),
      .status             (status),
      .event_kind         (rsp_chan.event_kind),
      .is_milestone       (rsp_chan.is_milestone),
      .event_time         (rsp_chan.event_time),
      .event_distance     (rsp_chan.event_distance),
      .last_event         (rsp_chan.last_event),
      .dropped_milestones (rsp_chan.dropped_milestones)
   );

endmodule

FILE: hdl/tmt_arith.sv
// tmt_arith: shared multi-cycle unit for floor(x*y/z), x*y and integer square root
// depends on tmt_pkg
`timescale 1ns / 1ps

module tmt_arith import tmt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  arith_mode_type mode,
   input  logic [63:0]    x,
   input  logic [63:0]    y,
   input  logic [63:0]    z,
   output logic           done,
   output logic [63:0]    result
);

   localparam logic [5:0] MUL_LAST  = 6'd4;
   localparam logic [5:0] DIV_LAST  = 6'd63;
   localparam logic [5:0] SQRT_LAST = 6'd31;

   ar_state_type   state_ff, state_in;
   logic [5:0]     step_ff, step_in;
   logic [127:0]   acc_ff, acc_in;
   logic [63:0]    prod_ff, prod_in;
   logic [63:0]    xs_ff, ys_ff, zs_ff;
   logic [63:0]    root_ff, root_in;
   logic [63:0]    bit_ff, bit_in;
   arith_mode_type mode_ff;
   logic           done_ff, done_in;
   logic [63:0]    res_ff, res_in;

   logic [31:0]    mx, my;
   logic [127:0]   addend;
   logic           sat;
   logic [63:0]    rem2, rem3, lo2;
   logic           take;
   logic [63:0]    trial, sx2, root2;
   logic           ge;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         AR_IDLE: begin
            if (start) state_in = (mode == AM_SQRT) ? AR_SQRT : AR_MUL;
         end
         AR_MUL: begin
            if (step_ff == MUL_LAST) state_in = AR_CHK;
         end
         AR_CHK: begin
            state_in = (mode_ff == AM_MULDIV && !sat) ? AR_DIV : AR_IDLE;
         end
         AR_DIV: begin
            if (step_ff == DIV_LAST) state_in = AR_IDLE;
         end
         AR_SQRT: begin
            if (step_ff == SQRT_LAST) state_in = AR_IDLE;
         end
         default: state_in = AR_IDLE;
      endcase
   end

   // one 32x32 partial product per cycle
   always_comb begin
      case (step_ff[1:0])
         2'd0:    begin mx = xs_ff[31:0];  my = ys_ff[31:0];  end
         2'd1:    begin mx = xs_ff[31:0];  my = ys_ff[63:32]; end
         2'd2:    begin mx = xs_ff[63:32]; my = ys_ff[31:0];  end
         default: begin mx = xs_ff[63:32]; my = ys_ff[63:32]; end
      endcase
      prod_in = 64'(mx) * 64'(my);
      case (step_ff[2:0])
         3'd1:    addend = {64'd0, prod_ff};
         3'd2,
         3'd3:    addend = {32'd0, prod_ff, 32'd0};
         3'd4:    addend = {prod_ff, 64'd0};
         default: addend = 128'd0;
      endcase
   end

   // restoring division step and root step
   always_comb begin
      sat   = (zs_ff == 64'd0) || (acc_ff[127:64] >= zs_ff);
      rem2  = {acc_ff[126:64], acc_ff[63]};
      take  = acc_ff[127] || (rem2 >= zs_ff);
      rem3  = take ? (rem2 - zs_ff) : rem2;
      lo2   = {acc_ff[62:0], take};
      trial = root_ff + bit_ff;
      ge    = acc_ff[63:0] >= trial;
      sx2   = ge ? (acc_ff[63:0] - trial) : acc_ff[63:0];
      root2 = ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
   end

   // outputs
   always_comb begin
      step_in = step_ff + 6'd1;
      acc_in  = acc_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      unique case (state_ff)
         AR_IDLE: begin
            step_in = 6'd0;
            // the root works on the operand, the product sums from zero
            acc_in  = (mode == AM_SQRT) ? {64'd0, x} : 128'd0;
            root_in = 64'd0;
            bit_in  = 64'd1 << 62;
         end
         AR_MUL: begin
            acc_in = acc_ff + addend;
         end
         AR_CHK: begin
            step_in = 6'd0;
            if (mode_ff == AM_MUL) begin
               done_in = 1'b1;
               res_in  = acc_ff[63:0];
            end else if (sat) begin
               done_in = 1'b1;
               res_in  = '1;
            end
         end
         AR_DIV: begin
            acc_in = {rem3, lo2};
            if (step_ff == DIV_LAST) begin
               done_in = 1'b1;
               res_in  = lo2;
            end
         end
         AR_SQRT: begin
            acc_in  = {64'd0, sx2};
            root_in = root2;
            bit_in  = bit_ff >> 2;
            if (step_ff == SQRT_LAST) begin
               done_in = 1'b1;
               res_in  = root2;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      res_ff  <= res_in;
      if (state_ff == AR_IDLE && start) begin
         xs_ff   <= x;
         ys_ff   <= y;
         zs_ff   <= z;
         mode_ff <= mode;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: hdl/tmt_datapath.sv
// tmt_datapath: configuration, plan registers, operand selection and result register
// depends on tmt_pkg and tmt_arith
`timescale 1ns / 1ps

module tmt_datapath import tmt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic [31:0] track_length,
   input  logic [31:0] speed_cap,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [1:0]  event_kind,
   output logic        is_milestone,
   output logic [31:0] event_time,
   output logic [31:0] event_distance,
   output logic        last_event,
   output logic        dropped_milestones
);

   localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] ONE2 = 64'd1 << (2 * FRAC_BITS);
   localparam logic [63:0] M32  = 64'h0000_0000_FFFF_FFFF;

   function automatic logic [63:0] sat_add(input logic [63:0] p, input logic [63:0] q);
      logic [64:0] s;
      s = {1'b0, p} + {1'b0, q};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [31:0] clip(input logic [63:0] p);
      return (p > M32) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   logic [31:0] accel_ff, decel_ff, spacing_ff;
   logic [15:0] bound_ff;
   logic [63:0] len_ff, v_ff, vb_ff, sa_ff, sd_ff, ta_ff, td_ff, tc_ff;
   logic [63:0] tmp_ff, tmp2_ff, off_ff, ds_ff, md_ff;
   logic [1:0]  kind_ff;
   logic        ms_ff, last_ff, drop_ff;
   logic [31:0] time_ff, dist_ff;

   logic [63:0] a, d, sp;
   logic [63:0] pt2_trap, pt2, pt3, ps2, sc, disc;
   logic [63:0] pt_cur, ps_cur, ps_next;
   logic [1:0]  phase_next;
   logic [63:0] opx, opy, opz, time64, dist64;
   arith_mode_type mode;
   logic        ar_done;
   logic [63:0] ar_res;

   // effective rates and spacing: zero counts as one lsb
   always_comb begin
      a  = (accel_ff == 32'd0) ? 64'd1 : 64'(accel_ff);
      d  = (decel_ff == 32'd0) ? 64'd1 : 64'(decel_ff);
      sp = (spacing_ff == 32'd0) ? 64'd1 : 64'(spacing_ff);
   end

   // phase boundaries
   always_comb begin
      sc       = len_ff - sa_ff - sd_ff;
      pt2_trap = sat_add(ta_ff, tc_ff);
      pt2      = cmd.trap ? pt2_trap : sat_add(ta_ff, td_ff);
      pt3      = sat_add(pt2_trap, td_ff);
      ps2      = cmd.trap ? (len_ff - sd_ff) : len_ff;
      case (cmd.phase)
         2'd0:    begin pt_cur = 64'd0; ps_cur = 64'd0;  end
         2'd1:    begin pt_cur = ta_ff; ps_cur = sa_ff;  end
         2'd2:    begin pt_cur = pt2;   ps_cur = ps2;    end
         default: begin pt_cur = pt3;   ps_cur = len_ff; end
      endcase
      phase_next = cmd.phase + 2'd1;
      case (phase_next)
         2'd0:    ps_next = 64'd0;
         2'd1:    ps_next = sa_ff;
         2'd2:    ps_next = ps2;
         default: ps_next = len_ff;
      endcase
      disc = (tmp2_ff > (tmp_ff >> 1)) ? 64'd0 : (tmp_ff - (tmp2_ff << 1));
   end

   // operand selection for the arithmetic unit
   always_comb begin
      opx  = vb_ff;
      opy  = ONE;
      opz  = a;
      mode = AM_MULDIV;
      case (cmd.calc)
         C_SA, C_SPK: begin opy = vb_ff; opz = a << 1; end
         C_SD:        begin opy = vb_ff; opz = d << 1; end
         C_TA:        ;
         C_TD:        opz = d;
         C_TC:        begin opx = sc; opz = vb_ff; end
         C_AD:        begin opx = a; opy = d; mode = AM_MUL; end
         C_Q:         begin opx = tmp_ff; opy = len_ff << 1; opz = a + d; end
         C_VP:        begin opx = tmp_ff; mode = AM_SQRT; end
         C_AQ:        begin opx = ds_ff << 1; opy = ONE2; end
         C_ASQ:       begin opx = tmp_ff; mode = AM_SQRT; end
         C_CR:        begin opx = ds_ff; opz = v_ff; end
         C_B0:        begin opx = ds_ff; opz = vb_ff; end
         C_VV:        begin opy = vb_ff; mode = AM_MUL; end
         C_P:         begin opx = d; opy = ds_ff; mode = AM_MUL; end
         C_BSQ:       begin opx = disc; mode = AM_SQRT; end
         C_BR:        begin opx = ds_ff << 1; opz = vb_ff + tmp_ff; end
         default:     ;
      endcase
   end

   tmt_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .mode   (mode),
      .x      (opx),
      .y      (opy),
      .z      (opz),
      .done   (ar_done),
      .result (ar_res)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff   <= 32'd65536;
         decel_ff   <= 32'd65536;
         spacing_ff <= 32'd65536;
         bound_ff   <= 16'd1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_ACCEL:   accel_ff   <= csr_write_data;
            REG_DECEL:   decel_ff   <= csr_write_data;
            REG_SPACING: spacing_ff <= csr_write_data;
            REG_BOUND:   bound_ff   <= csr_write_data[15:0];
            default:     ;
         endcase
      end
   end

   // plan registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            len_ff <= 64'(track_length);
            v_ff   <= (speed_cap == 32'd0) ? 64'd1 : 64'(speed_cap);
            vb_ff  <= (speed_cap == 32'd0) ? 64'd1 : 64'(speed_cap);
            md_ff  <= sp;
         end
         OP_DS:     ds_ff  <= md_ff - ps_cur;
         OP_OFFMAX: off_ff <= '1;
         OP_MDINC:  md_ff  <= md_ff + sp;
         default:   ;
      endcase
      if (ar_done) begin
         case (cmd.calc)
            C_SA, C_SPK:             sa_ff   <= ar_res;
            C_SD:                    sd_ff   <= ar_res;
            C_TA:                    ta_ff   <= ar_res;
            C_TD:                    td_ff   <= ar_res;
            C_TC:                    tc_ff   <= ar_res;
            C_AD, C_Q, C_AQ, C_VV,
            C_BSQ:                   tmp_ff  <= ar_res;
            C_VP:                    vb_ff   <= ar_res;
            C_P:                     tmp2_ff <= ar_res;
            C_ASQ, C_CR, C_B0, C_BR: off_ff  <= ar_res;
            default:                 ;
         endcase
      end
   end

   // result register
   always_comb begin
      time64 = cmd.is_ms ? sat_add(pt_cur, off_ff) : pt_cur;
      dist64 = cmd.is_ms ? md_ff : ps_cur;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff <= cmd.kind;
         ms_ff   <= cmd.is_ms;
         last_ff <= cmd.last;
         drop_ff <= cmd.drop;
         time_ff <= clip(time64);
         dist_ff <= clip(dist64);
      end
   end

   always_comb begin
      status.done    = ar_done;
      status.fits    = (sa_ff + sd_ff) <= len_ff;
      status.ms_more = md_ff < ps_next;
      status.a_small = a < 64'(bound_ff);
      status.d_small = d < 64'(bound_ff);
   end

   assign event_kind         = kind_ff;
   assign is_milestone       = ms_ff;
   assign event_time         = time_ff;
   assign event_distance     = dist_ff;
   assign last_event         = last_ff;
   assign dropped_milestones = drop_ff;

endmodule

FILE: hdl/tmt_ctrl.sv
// tmt_ctrl: sequencer of the plan, the phase walk and the milestone events
// depends on tmt_pkg
`timescale 1ns / 1ps

module tmt_ctrl import tmt_pkg::*; #(
   parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CNT_W = $clog2(MAX_EVENTS + 1);

   ctl_state_type state_ff, state_in;
   calc_type      calc_ff, calc_in;
   logic          trap_ff, trap_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          drop_ff, drop_in;
   logic          halt_ff, halt_in;
   logic          outv_ff, outv_in;

   logic          emit_ok, more, full;
   logic [1:0]    n, kind;
   logic [CNT_W+1:0] need;

   always_comb begin
      emit_ok = !outv_ff || rsp_ready;
      n       = trap_ff ? 2'd3 : 2'd2;
      if (phase_ff == 2'd0)                 kind = K_ACCEL;
      else if (trap_ff && phase_ff == 2'd1) kind = K_CRUISE;
      else                                  kind = K_BRAKE;
      more = !halt_ff && status.ms_more;
      need = (CNT_W + 2)'(cnt_ff) + (CNT_W + 2)'(n - phase_ff);
      full = need >= (CNT_W + 2)'(MAX_EVENTS);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      calc_in  = calc_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_GO;
               calc_in  = C_SA;
            end
         end
         CS_GO: state_in = CS_WAIT;
         CS_WAIT: begin
            if (status.done) begin
               state_in = CS_GO;
               case (calc_ff)
                  C_SA:  calc_in = C_SD;
                  C_SD:  state_in = CS_FIT;
                  C_TA:  calc_in = C_TD;
                  C_TD: begin
                     if (trap_ff) calc_in = C_TC;
                     else state_in = CS_PHASE;
                  end
                  C_TC:  state_in = CS_PHASE;
                  C_AD:  calc_in = C_Q;
                  C_Q:   calc_in = C_VP;
                  C_VP:  calc_in = C_SPK;
                  C_SPK: calc_in = C_TA;
                  C_AQ:  calc_in = C_ASQ;
                  C_VV:  calc_in = C_P;
                  C_P:   calc_in = C_BSQ;
                  C_BSQ: calc_in = C_BR;
                  default: state_in = CS_MS;
               endcase
            end
         end
         CS_FIT: begin
            state_in = CS_GO;
            calc_in  = status.fits ? C_TA : C_AD;
         end
         CS_PHASE: begin
            if (emit_ok) state_in = CS_CHECK;
         end
         CS_CHECK: begin
            if (more) begin
               if (!full) begin
                  state_in = CS_GO;
                  case (kind)
                     K_ACCEL: begin
                        if (status.a_small) state_in = CS_MS;
                        else calc_in = C_AQ;
                     end
                     K_CRUISE: calc_in = C_CR;
                     default:  calc_in = status.d_small ? C_B0 : C_VV;
                  endcase
               end
            end else begin
               state_in = (phase_ff + 2'd1 == n) ? CS_STOP : CS_PHASE;
            end
         end
         CS_MS: begin
            if (emit_ok) state_in = CS_CHECK;
         end
         CS_STOP: begin
            if (emit_ok) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.calc  = calc_ff;
      cmd.start = 1'b0;
      cmd.emit  = 1'b0;
      cmd.kind  = kind;
      cmd.is_ms = 1'b0;
      cmd.last  = 1'b0;
      cmd.drop  = 1'b0;
      cmd.phase = phase_ff;
      cmd.trap  = trap_ff;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         CS_GO: cmd.start = 1'b1;
         CS_PHASE: cmd.emit = emit_ok;
         CS_CHECK: begin
            if (more && !full) begin
               cmd.op = (kind == K_ACCEL && status.a_small) ? OP_OFFMAX : OP_DS;
            end
         end
         CS_MS: begin
            cmd.is_ms = 1'b1;
            cmd.emit  = emit_ok;
            if (emit_ok) cmd.op = OP_MDINC;
         end
         CS_STOP: begin
            cmd.kind = K_STOP;
            cmd.last = 1'b1;
            cmd.drop = drop_ff;
            cmd.emit = emit_ok;
         end
         default: ;
      endcase
   end

   // counters and flags
   always_comb begin
      trap_in  = trap_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      halt_in  = halt_ff;
      outv_in  = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : outv_ff);
      if (state_ff == CS_IDLE && req_valid) begin
         phase_in = 2'd0;
         cnt_in   = '0;
         drop_in  = 1'b0;
         halt_in  = 1'b0;
      end
      if (state_ff == CS_FIT) trap_in = status.fits;
      if ((state_ff == CS_PHASE || state_ff == CS_MS) && emit_ok) cnt_in = cnt_ff + 1'b1;
      if (state_ff == CS_CHECK) begin
         if (more && full) begin
            drop_in = 1'b1;
            halt_in = 1'b1;
         end else if (!more) begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         calc_ff  <= C_NONE;
         trap_ff  <= 1'b0;
         phase_ff <= 2'd0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         halt_ff  <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         calc_ff  <= calc_in;
         trap_ff  <= trap_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         halt_ff  <= halt_in;
         outv_ff  <= outv_in;
      end
   end

   assign rsp_valid = outv_ff;

endmodule

FILE: hdl/tmt_checker.sv
// tmt_checker: port-level checks on the result channel, bound to the top level
// depends on tmt_pkg and trapezoid_motion_timeline
`timescale 1ns / 1ps

module tmt_checker import tmt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  event_kind,
   input logic        is_milestone,
   input logic        last_event,
   input logic        dropped_milestones
);

   // the stop event alone ends a run
   a_last_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_event == (event_kind == K_STOP)))
      else $error("last_event does not match stop kind");

   // drop flag only on the last event
   a_drop_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped_milestones |-> last_event)
      else $error("dropped flag outside the stop event");

   // a milestone never carries the stop kind
   a_ms_not_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_milestone |-> (event_kind != K_STOP))
      else $error("milestone with stop kind");

   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind trapezoid_motion_timeline tmt_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .event_kind         (rsp_chan.event_kind),
   .is_milestone       (rsp_chan.is_milestone),
   .last_event         (rsp_chan.last_event),
   .dropped_milestones (rsp_chan.dropped_milestones)
);
